FILE: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared types and codes for controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
	localparam int UNIT_SHIFT = 5;

	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_REPORT  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_CUR,
		OP_STEP,
		OP_ALLOC_WR,
		OP_SPLIT_WR,
		OP_REL_CHK,
		OP_RD_NEXT,
		OP_REL_WR,
		OP_RD_PREV,
		OP_MERGE_PREV,
		OP_CLEAR,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic [1:0] st;
	} ctl_cmd_t;

	typedef struct packed {
		logic walk_end;   // current pointer out of arena or not a header
		logic fits;       // free and large enough
		logic need_split; // remainder is a new header
		logic req_zero;
		logic off_bad;    // release offset malformed
		logic tgt_bad;    // release target not a used header
		logic at_target;  // walk reached release target or end of list
		logic nxt_free;   // next neighbor is a free header
		logic has_prev;
		logic prev_free;
		logic clr_done;
	} ctl_sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/ffha_ram.sv
// ----------------------------------------------------------------------------
// Generic single port RAM
// One read per cycle, plus a write when we is high; registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/ffha_dp.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Block table memory, walk pointers, size arithmetic and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_dp
	import ffha_pkg::*;
#(
	parameter int ARENA_UNITS = 512
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ctl_cmd_t      cmd,
	input  wire logic [1:0]    func,
	input  wire logic [13:0]   request_bytes,
	input  wire logic [14:0]   release_offset,
	output ctl_sts_t           sts,
	output logic               done,
	output logic [1:0]         status,
	output logic [14:0]        payload_offset,
	output logic [13:0]        largest_free_bytes
);
	localparam int AW = $clog2(ARENA_UNITS);
	localparam int PW = AW + 1;
	localparam int EW = AW + 2;
	localparam logic [PW-1:0] ARENA = PW'(ARENA_UNITS);

	logic [PW-1:0] cur_q, prev_q, tgt_q, nxt_q, need_q, best_q, cnt_q;
	logic [AW-1:0] cur_units_q, tgt_units_q;
	logic          has_prev_q, prev_free_q;
	logic [1:0]    func_q;
	logic [13:0]   req_q;
	logic [14:0]   off_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [EW-1:0] wdata, rdata;
	logic          r_hdr, r_fre;
	logic [AW-1:0] r_units;

	assign r_hdr   = rdata[EW-1];
	assign r_fre   = rdata[EW-2];
	assign r_units = rdata[AW-1:0];

	ffha_ram #(.WIDTH(EW), .DEPTH(ARENA_UNITS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [PW-1:0] next_ptr, tgt_unit;
	logic [PW:0]   next_sum;
	logic [14:0]   need_full;
	assign next_sum = {1'b0, cur_q} + (PW+1)'(r_units) + 1'b1;
	assign next_ptr = (next_sum > {1'b0, ARENA}) ? ARENA : next_sum[PW-1:0];
	assign tgt_unit = PW'((off_q >> UNIT_SHIFT) - 15'd1);
	assign need_full = (15'(request_bytes) + 15'd31) >> UNIT_SHIFT;

	always_comb begin
		we    = 1'b0;
		addr  = cur_q[AW-1:0];
		wdata = '0;
		case (cmd.op)
			OP_ALLOC_WR: begin
				we    = 1'b1;
				wdata = {1'b1, 1'b0, (need_q < PW'(r_units)) ? need_q[AW-1:0] : r_units};
			end
			OP_SPLIT_WR: begin
				we    = 1'b1;
				addr  = AW'(cur_q + need_q + 1'b1);
				wdata = {1'b1, 1'b1, AW'(cur_units_q - need_q[AW-1:0] - 1'b1)};
			end
			OP_REL_CHK, OP_RD_NEXT: addr = tgt_q[AW-1:0];
			OP_REL_WR: begin
				addr = nxt_q[AW-1:0];
			end
			OP_RD_PREV: begin
				we    = 1'b1;
				addr  = tgt_q[AW-1:0];
				wdata = {1'b1, 1'b1, tgt_units_q};
			end
			OP_MERGE_PREV: begin
				we    = 1'b1;
				addr  = prev_q[AW-1:0];
				wdata = {1'b1, 1'b1, AW'(cur_units_q + tgt_units_q + 1'b1)};
			end
			OP_CLEAR: begin
				we    = 1'b1;
				addr  = cnt_q[AW-1:0];
				wdata = (cnt_q == '0) ? {1'b1, 1'b1, AW'(ARENA_UNITS - 1)} : '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts            = '0;
		sts.walk_end   = (cur_q >= ARENA) || !r_hdr;
		sts.fits       = r_fre && (PW'(r_units) >= need_q);
		sts.need_split = PW'(cur_units_q) > need_q;
		sts.req_zero   = (req_q == 14'd0);
		sts.off_bad    = (off_q == 15'd0) || (off_q[UNIT_SHIFT-1:0] != '0) ||
		                 (tgt_unit >= ARENA) || ((off_q >> UNIT_SHIFT) > 15'(ARENA_UNITS));
		sts.tgt_bad    = !r_hdr || r_fre;
		sts.at_target  = (cur_q >= tgt_q) || (cur_q >= ARENA) || !r_hdr;
		sts.nxt_free   = (nxt_q < ARENA) && r_hdr && r_fre;
		sts.has_prev   = has_prev_q;
		sts.prev_free  = prev_free_q;
		sts.clr_done   = (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done   <= 1'b0;
			cnt_q  <= PW'(ARENA_UNITS - 1);
		end else begin
			done <= (cmd.op == OP_DONE);
			if (cmd.op == OP_CLEAR && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q      <= func;
				req_q       <= request_bytes;
				off_q       <= release_offset;
				need_q      <= (need_full > 15'(ARENA_UNITS)) ? ARENA : PW'(need_full);
				cur_q       <= '0;
				best_q      <= '0;
				has_prev_q  <= 1'b0;
			end
			OP_RD_CUR: begin
				tgt_q <= tgt_unit;
			end
			OP_STEP: begin
				if (func_q == FUNC_REPORT && r_fre && PW'(r_units) > best_q) begin
					best_q <= PW'(r_units);
				end
				if (func_q == FUNC_RELEASE) begin
					prev_q      <= cur_q;
					prev_free_q <= r_fre;
					has_prev_q  <= 1'b1;
				end
				cur_units_q <= r_units;
				cur_q       <= next_ptr;
			end
			OP_ALLOC_WR: begin
				cur_units_q <= r_units;
			end
			OP_REL_CHK: begin
				tgt_units_q <= r_units;
				nxt_q       <= PW'(tgt_q + PW'(r_units) + 1'b1);
			end
			OP_REL_WR: ;
			default: ;
		endcase
		if (cmd.op == OP_RD_NEXT && sts.nxt_free) begin
			tgt_units_q <= AW'(tgt_units_q + r_units + 1'b1);
		end
		if (cmd.op == OP_DONE) begin
			status             <= cmd.st;
			payload_offset     <= (cmd.st == ST_OK && func_q == FUNC_ALLOC) ?
			                      15'((32'(cur_q) + 32'd1) << UNIT_SHIFT) : 15'd0;
			largest_free_bytes <= (cmd.st == ST_OK && func_q == FUNC_REPORT) ?
			                      (((32'(best_q) << UNIT_SHIFT) > 32'h3FFF) ?
			                       14'h3FFF : 14'(32'(best_q) << UNIT_SHIFT)) : 14'd0;
		end
		if (cmd.op == OP_MERGE_PREV) begin
			cur_units_q <= cur_units_q;
		end
	end
	// prev_q units captured in cur_units_q by last STEP before target
endmodule
`default_nettype wire

FILE: rtl/core/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences reset clear, first-fit walk, release and report.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_ctrl
	import ffha_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic [1:0] func,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      cmd,
	output logic          busy
);
	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_INIT   = 4'd1;
	localparam logic [3:0] S_IDLE   = 4'd2;
	localparam logic [3:0] S_RD     = 4'd3;
	localparam logic [3:0] S_EVAL   = 4'd4;
	localparam logic [3:0] S_SPLIT  = 4'd5;
	localparam logic [3:0] S_RCHK   = 4'd6;
	localparam logic [3:0] S_RWALK  = 4'd7;
	localparam logic [3:0] S_RNEXT  = 4'd8;
	localparam logic [3:0] S_RNX2   = 4'd9;
	localparam logic [3:0] S_RFREE  = 4'd10;
	localparam logic [3:0] S_RPREV  = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;
	localparam logic [3:0] S_ALW    = 4'd13;
	localparam logic [3:0] S_RCHK2  = 4'd14;
	localparam logic [3:0] S_RWRD   = 4'd15;

	logic [3:0] state_q, state_d;
	logic [1:0] func_q, st_q, st_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '{op: OP_NONE, st: st_q};
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_done) state_d = S_INIT;
			end
			S_INIT: begin
				cmd.op = OP_NONE;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					st_d    = ST_OK;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.op = OP_RD_CUR;
				case (func_q)
					FUNC_ALLOC: begin
						st_d = ST_BAD;
						state_d = sts.req_zero ? S_DONE : S_EVAL;
						if (!sts.req_zero) st_d = ST_OK;
					end
					FUNC_REPORT: state_d = S_EVAL;
					FUNC_RELEASE: state_d = S_RCHK;
					default: begin
						st_d = ST_BAD;
						state_d = S_DONE;
					end
				endcase
			end
			S_EVAL: begin
				if (sts.walk_end) begin
					if (func_q == FUNC_ALLOC) st_d = ST_NO_FIT;
					state_d = S_DONE;
				end else if (func_q == FUNC_ALLOC && sts.fits) begin
					cmd.op  = OP_ALLOC_WR;
					state_d = S_ALW;
				end else begin
					cmd.op  = OP_STEP;
					state_d = S_RD;
				end
			end
			S_ALW: begin
				if (sts.need_split) cmd.op = OP_SPLIT_WR;
				state_d = S_DONE;
			end
			S_RCHK: begin
				if (sts.off_bad) begin
					st_d = ST_BAD;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_REL_CHK;
					state_d = S_RCHK2;
				end
			end
			S_RCHK2: begin
				cmd.op = OP_REL_CHK;
				if (sts.tgt_bad) begin
					st_d = ST_BAD;
					state_d = S_DONE;
				end else begin
					state_d = S_RWRD;
				end
			end
			S_RWRD: begin
				cmd.op = OP_RD_CUR;
				state_d = S_RWALK;
			end
			S_RWALK: begin
				if (sts.at_target) begin
					cmd.op = OP_REL_WR;
					state_d = S_RNEXT;
				end else begin
					cmd.op = OP_STEP;
					state_d = S_RWRD;
				end
			end
			S_RNEXT: begin
				cmd.op = OP_RD_NEXT;
				state_d = S_RNX2;
			end
			S_RNX2: begin
				cmd.op = OP_RD_PREV;
				state_d = S_RFREE;
			end
			S_RFREE: begin
				if (sts.has_prev && sts.prev_free) cmd.op = OP_MERGE_PREV;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.op  = OP_DONE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			st_q    <= ST_OK;
			func_q  <= FUNC_ALLOC;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (state_q == S_IDLE && start) func_q <= func;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator over an arena of ARENA_UNITS 32-byte units.
// done is never held off. Throughput: one item at a time; the next start is taken in
// the cycle done is high. Reset: a clearing pass writes the block table with unit 0
// as one free block, then the controller passes through its init state; busy is high
// during it.
// ----------------------------------------------------------------------------
// First-fit heap allocator top level
// Controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int ARENA_UNITS = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [13:0] request_bytes,
	input  wire logic [14:0] release_offset,
	output logic             done,
	output logic [1:0]       status,
	output logic [14:0]      payload_offset,
	output logic [13:0]      largest_free_bytes
);
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	ffha_dp #(.ARENA_UNITS(ARENA_UNITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .func(func),
		.request_bytes(request_bytes), .release_offset(release_offset),
		.sts(sts), .done(done), .status(status),
		.payload_offset(payload_offset), .largest_free_bytes(largest_free_bytes)
	);
endmodule
`default_nettype wire

FILE: rtl/core/ffha_chk.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_chk
	import ffha_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [14:0] payload_offset,
	input wire logic [13:0] largest_free_bytes
);
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("bad status code");
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> payload_offset == 15'd0 && largest_free_bytes == 14'd0)
		else $error("payload on failed item");
endmodule

bind first_fit_heap_allocator ffha_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .payload_offset(payload_offset),
	.largest_free_bytes(largest_free_bytes)
);
`default_nettype wire

FILE: test/first_fit_heap_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate, release, report and invalid-function items against a behavioral arena model
// and compares each done strobe field by field with the predicted outcome.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator_test;
	import ffha_pkg::*;

	localparam int UNITS = 512;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [1:0]  func;
		logic [13:0] req;
		logic [14:0] off;
	} item_t;

	typedef struct {
		logic [1:0]  status;
		logic [14:0] offset;
		logic [13:0] largest;
	} outcome_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] func = '0;
	logic [13:0] request_bytes = '0;
	logic [14:0] release_offset = '0;
	logic busy, done;
	logic [1:0] status;
	logic [14:0] payload_offset;
	logic [13:0] largest_free_bytes;

	first_fit_heap_allocator #(.ARENA_UNITS(UNITS)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.request_bytes(request_bytes), .release_offset(release_offset),
		.done(done), .status(status), .payload_offset(payload_offset),
		.largest_free_bytes(largest_free_bytes)
	);

	// arena model
	bit hdr[UNITS];
	bit fre[UNITS];
	int len[UNITS];
	int live_offsets[$];

	item_t pending_items[$];
	outcome_t expected_outcomes[$];
	int errors = 0;
	int cycles = 0;
	int gap = 0;
	bit idle_on = 1;
	int n_ok = 0, n_nofit = 0, n_bad = 0, n_merge = 0;

	initial forever #4 clk = ~clk;

	function automatic void arena_reset();
		for (int i = 0; i < UNITS; i++) begin
			hdr[i] = 0;
			fre[i] = 0;
			len[i] = 0;
		end
		hdr[0] = 1;
		fre[0] = 1;
		len[0] = UNITS - 1;
	endfunction

	function automatic outcome_t arena_apply(item_t it);
		outcome_t o;
		int u, need, w, p, nx;
		bit has_prev;
		o.status = ST_OK;
		o.offset = '0;
		o.largest = '0;
		if (it.func == FUNC_ALLOC) begin
			if (it.req == 0) begin
				o.status = ST_BAD;
				return o;
			end
			need = (int'(it.req) + 31) / 32;
			u = 0;
			while (u < UNITS && hdr[u]) begin
				if (fre[u] && len[u] >= need) begin
					if (len[u] > need) begin
						hdr[u + 1 + need] = 1;
						fre[u + 1 + need] = 1;
						len[u + 1 + need] = len[u] - need - 1;
						len[u] = need;
					end
					fre[u] = 0;
					o.offset = 15'((u + 1) * 32);
					live_offsets.push_back((u + 1) * 32);
					return o;
				end
				u = u + 1 + len[u];
			end
			o.status = ST_NO_FIT;
		end else if (it.func == FUNC_RELEASE) begin
			if (it.off == 0 || it.off % 32 != 0) begin
				o.status = ST_BAD;
				return o;
			end
			u = int'(it.off) / 32 - 1;
			if (u >= UNITS || !hdr[u] || fre[u]) begin
				o.status = ST_BAD;
				return o;
			end
			for (int i = 0; i < live_offsets.size(); i++)
				if (live_offsets[i] == int'(it.off)) begin
					live_offsets.delete(i);
					break;
				end
			w = 0;
			p = 0;
			has_prev = 0;
			while (w < u && hdr[w]) begin
				p = w;
				has_prev = 1;
				w = w + 1 + len[w];
			end
			fre[u] = 1;
			nx = u + 1 + len[u];
			if (nx < UNITS && hdr[nx] && fre[nx]) begin
				len[u] += len[nx] + 1;
				hdr[nx] = 0;
				fre[nx] = 0;
				len[nx] = 0;
				n_merge++;
			end
			if (has_prev && fre[p]) begin
				len[p] += len[u] + 1;
				hdr[u] = 0;
				fre[u] = 0;
				len[u] = 0;
				n_merge++;
			end
		end else if (it.func == FUNC_REPORT) begin
			int best;
			best = 0;
			u = 0;
			while (u < UNITS && hdr[u]) begin
				if (fre[u] && len[u] > best)
					best = len[u];
				u = u + 1 + len[u];
			end
			o.largest = (best * 32 > 16383) ? 14'h3fff : 14'(best * 32);
		end else begin
			o.status = ST_BAD;
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic item_t make_item(logic [1:0] f, int r, int o);
		item_t it;
		it.func = f;
		it.req = 14'(r);
		it.off = 15'(o);
		return it;
	endfunction

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (start && busy) begin
				// hold until taken
			end else if (gap > 0 || pending_items.size() == 0) begin
				if (gap > 0)
					gap <= gap - 1;
				start <= 0;
			end else if (start && idle_on && $urandom_range(0, 7) == 0) begin
				gap <= $urandom_range(1, 17);
				start <= 0;
			end else begin
				item_t it;
				it = pending_items.pop_front();
				start <= 1;
				func <= it.func;
				request_bytes <= it.req;
				release_offset <= it.off;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (start && !busy && arst_n) begin
			item_t acc;
			acc.func = func;
			acc.req = request_bytes;
			acc.off = release_offset;
			expected_outcomes.push_back(arena_apply(acc));
		end
		if (done && arst_n) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				outcome_t e;
				e = expected_outcomes.pop_front();
				if (status !== e.status)
					report_mismatch("status", status, e.status);
				if (payload_offset !== e.offset)
					report_mismatch("payload_offset", payload_offset, e.offset);
				if (largest_free_bytes !== e.largest)
					report_mismatch("largest_free_bytes", largest_free_bytes, e.largest);
				case (e.status)
					ST_OK: n_ok++;
					ST_NO_FIT: n_nofit++;
					default: n_bad++;
				endcase
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() != 0 || start || expected_outcomes.size() != 0 || busy)
			@(posedge clk);
	endtask

	function automatic int live_pick();
		if (live_offsets.size() == 0)
			return 32;
		return live_offsets[$urandom_range(0, live_offsets.size() - 1)];
	endfunction

	initial begin
		int k, r;
		arena_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed
		pending_items.push_back(make_item(FUNC_REPORT, 0, 0));
		pending_items.push_back(make_item(FUNC_ALLOC, 0, 0));
		pending_items.push_back(make_item(FUNC_ALLOC, 16352, 0));
		pending_items.push_back(make_item(FUNC_ALLOC, 1, 0));
		pending_items.push_back(make_item(FUNC_ALLOC, 16383, 0));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 32));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 32));
		pending_items.push_back(make_item(FUNC_ALLOC, 16320, 0));
		pending_items.push_back(make_item(FUNC_REPORT, 0, 0));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 32));
		pending_items.push_back(make_item(FUNC_ALLOC, 31, 0));
		pending_items.push_back(make_item(FUNC_ALLOC, 33, 0));
		pending_items.push_back(make_item(FUNC_ALLOC, 64, 0));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 96));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 32));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 192));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 0));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 33));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 32736));
		pending_items.push_back(make_item(FUNC_RELEASE, 0, 16384));
		pending_items.push_back(make_item(2'd3, 16383, 32767));
		pending_items.push_back(make_item(FUNC_REPORT, 0, 0));
		wait_drained();
		// live offsets depend on accepted history, so the random item queue is kept at most two deep
		for (k = 0; k < 900; k++) begin
			if (k == 450)
				wait_drained();
			if (k == 780)
				idle_on = 0;
			while (pending_items.size() > 1)
				@(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 45)
				pending_items.push_back(make_item(FUNC_ALLOC,
					($urandom_range(0, 5) == 0) ? $urandom_range(0, 16383)
						: $urandom_range(1, 800), 0));
			else if (r < 85) begin
				if ($urandom_range(0, 3) == 0)
					pending_items.push_back(make_item(FUNC_RELEASE, 0,
						$urandom_range(0, 32767)));
				else begin
					// release targets are chosen when the item is next to go in
					while (pending_items.size() != 0 || (start && busy))
						@(posedge clk);
					pending_items.push_back(make_item(FUNC_RELEASE, 0, live_pick()));
				end
			end else if (r < 95)
				pending_items.push_back(make_item(FUNC_REPORT,
					$urandom_range(0, 16383), $urandom_range(0, 32767)));
			else
				pending_items.push_back(make_item(2'd3,
					$urandom_range(0, 16383), $urandom_range(0, 32767)));
		end
		wait_drained();
		repeat (2 * UNITS + 20) @(posedge clk);
		$display("covered %0d ok, %0d no-fit and %0d bad-request results, %0d merges",
			n_ok, n_nofit, n_bad, n_merge);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
